### design/pixel_brightness_contrast_macros.svh
// Assertion macros shared by the pixel brightness and contrast design.
`ifndef PIXEL_BRIGHTNESS_CONTRAST_MACROS_SVH
`define PIXEL_BRIGHTNESS_CONTRAST_MACROS_SVH

`ifndef ASSERT_OFF
// Checks a property at every clock edge outside reset.
`define PBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define PBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBC_ASSERT(label, prop, msg)
`define PBC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### design/pbc_pkg.sv
// Types and constants for the pixel brightness and contrast block.
`timescale 1ns / 1ps

package pbc_pkg;

    localparam int NUM_CH = 4;
    localparam int CH_W   = 8;

    localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [CH_W-1:0] MID_LEVEL  = 8'd127;

    localparam logic [8:0] CONTRAST_RESET = 9'd100;

    // Reciprocals of 100 for the two constant divisions.
    localparam logic [12:0] RECIP_BRIGHT = 13'd5243;   // 2^19 / 100, rounded up
    localparam int          SHIFT_BRIGHT = 19;
    localparam logic [16:0] RECIP_CON    = 17'd83887;  // 2^23 / 100, rounded up
    localparam int          SHIFT_CON    = 23;

    typedef enum logic [1:0] {
        CFG_MODE         = 2'd0,
        CFG_BRIGHTNESS   = 2'd1,
        CFG_CONTRAST     = 2'd2,
        CFG_ALPHA_ENABLE = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_BRIGHTNESS = 1'b0,
        MODE_CONTRAST   = 1'b1
    } mode_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
    } result_t;

endpackage

### design/pbc_stream_if.sv
// Valid/ready stream interface that carries one pixel item per handshake.
`timescale 1ns / 1ps

interface pbc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/pixel_brightness_contrast.sv
// Three-stage pixel brightness and contrast adjustment pipeline.
// An accepted item moves through the channel, product/sum and result registers in turn.
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// The contrast path uses two multipliers per channel, one stage apart, which sets the depth.
// Reset empties the pipeline and loads mode 0, brightness 0, contrast 100, alpha disabled.
`timescale 1ns / 1ps
`include "pixel_brightness_contrast_macros.svh"

module pixel_brightness_contrast (
    input  logic                   clk,
    input  logic                   rst_n,
    pbc_stream_if.sink             pix_in,
    pbc_stream_if.source           pix_out,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [8:0]             cfg_wdata
);

    localparam int NC = pbc_pkg::NUM_CH;
    localparam int CW = pbc_pkg::CH_W;

    // Configuration; brightness is kept as its offset, brightness*255/100.
    pbc_pkg::mode_t    mode_reg;
    logic signed [9:0] bright_offset_reg;
    logic        [8:0] contrast_reg;
    logic              alpha_enable_reg;

    logic              valid_a_reg;
    logic              valid_b_reg;
    logic              valid_c_reg;
    logic              advance;

    logic [CW-1:0]      chan_in [NC];
    logic [CW-1:0]      chan_a_reg [NC];
    logic signed [17:0] prod_b_reg [NC];
    logic signed [17:0] prod_b_next [NC];
    logic signed [10:0] sum_b_reg [NC];
    logic signed [10:0] sum_b_next [NC];
    logic [CW-1:0]      chan_c_next [NC];
    pbc_pkg::result_t   result_reg;
    pbc_pkg::result_t   result_next;

    function automatic logic signed [9:0] bright_offset(input logic [7:0] b);
        logic [7:0]  mag;
        logic [15:0] scaled;
        logic [28:0] prod;
        logic [8:0]  q;
        mag    = b[7] ? (~b + 8'd1) : b;
        scaled = 16'(mag) * 16'(pbc_pkg::FULL_SCALE);
        prod   = 29'(scaled) * 29'(pbc_pkg::RECIP_BRIGHT);
        q      = prod[pbc_pkg::SHIFT_BRIGHT +: 9];
        return b[7] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Divides the contrast product by 100 toward zero and adds the mid level.
    function automatic logic signed [11:0] contrast_level(input logic signed [17:0] p);
        logic        [17:0] mag_full;
        logic        [16:0] mag;
        logic        [33:0] prod;
        logic        [10:0] q;
        mag_full = p[17] ? 18'(-p) : 18'(p);
        mag      = mag_full[16:0];
        prod     = 34'(mag) * 34'(pbc_pkg::RECIP_CON);
        q        = prod[pbc_pkg::SHIFT_CON +: 11];
        return p[17] ? (12'sd127 - $signed({1'b0, q}))
                     : (12'sd127 + $signed({1'b0, q}));
    endfunction

    function automatic logic [7:0] clamp_level(input logic signed [11:0] v);
        logic [7:0] r;
        if (v < 12'sd0)
        begin
            r = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            r = pbc_pkg::FULL_SCALE;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= pbc_pkg::MODE_BRIGHTNESS;
            bright_offset_reg <= '0;
            contrast_reg      <= pbc_pkg::CONTRAST_RESET;
            alpha_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pbc_pkg::CFG_MODE:         mode_reg <= pbc_pkg::mode_t'(cfg_wdata[0]);
                pbc_pkg::CFG_BRIGHTNESS:   bright_offset_reg <= bright_offset(cfg_wdata[7:0]);
                pbc_pkg::CFG_CONTRAST:     contrast_reg <= cfg_wdata;
                pbc_pkg::CFG_ALPHA_ENABLE: alpha_enable_reg <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // Every stage moves together whenever the output register is free or being taken.
    assign advance      = !valid_c_reg || pix_out.ready;
    assign pix_in.ready = advance;

    assign chan_in[0] = pix_in.data.red;
    assign chan_in[1] = pix_in.data.green;
    assign chan_in[2] = pix_in.data.blue;
    assign chan_in[3] = pix_in.data.alpha;

    always_comb
    begin
        logic signed [9:0]  diff;
        logic signed [19:0] full;
        for (int i = 0; i < NC; i++)
        begin
            diff           = $signed({2'b00, chan_a_reg[i]})
                           - $signed({2'b00, pbc_pkg::MID_LEVEL});
            full           = diff * $signed({1'b0, contrast_reg});
            prod_b_next[i] = full[17:0];
            sum_b_next[i]  = $signed({3'b000, chan_a_reg[i]}) + 11'(bright_offset_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            if (mode_reg == pbc_pkg::MODE_CONTRAST)
            begin
                chan_c_next[i] = clamp_level(contrast_level(prod_b_reg[i]));
            end
            else
            begin
                chan_c_next[i] = clamp_level(12'(sum_b_reg[i]));
            end
        end
        result_next.red_out   = chan_c_next[0];
        result_next.green_out = chan_c_next[1];
        result_next.blue_out  = chan_c_next[2];
        result_next.alpha_out = alpha_enable_reg ? chan_c_next[3] : pbc_pkg::FULL_SCALE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_a_reg <= pix_in.valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NC; i++)
            begin
                chan_a_reg[i] <= chan_in[i];
                prod_b_reg[i] <= prod_b_next[i];
                sum_b_reg[i]  <= sum_b_next[i];
            end
            result_reg <= result_next;
        end
    end

    assign pix_out.valid = valid_c_reg;
    assign pix_out.data  = result_reg;

    `PBC_ASSERT(a_offset_range,
        (bright_offset_reg >= -10'sd326) && (bright_offset_reg <= 10'sd323),
        "brightness offset out of range")
    `PBC_ASSERT_NEXT(a_stage_move, advance && valid_a_reg, valid_b_reg,
        "item lost between first and second stage")
    `PBC_ASSERT_NEXT(a_alpha_forced, advance && valid_b_reg && !alpha_enable_reg,
        pix_out.valid && (pix_out.data.alpha_out == 8'd255),
        "alpha not forced to full scale")

endmodule
